>>> design/lsi_pkg.sv
// ============================================================================
// lsi_pkg: shared types and constants for the line/sphere intersection unit
// Request and response payloads, per-lane status flags and the time clamp.
// ============================================================================
package lsi_pkg;

  localparam int COORD_BITS  = 24;
  localparam int RADIUS_BITS = COORD_BITS - 1;
  localparam int TIME_BITS   = 40;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {1'b0, {(TIME_BITS-1){1'b1}}};
  localparam logic [TIME_BITS-1:0] TIME_MIN = {1'b1, {(TIME_BITS-1){1'b0}}};

  // Track and sphere description
  typedef struct packed {
    logic signed [COORD_BITS-1:0] origin_x;
    logic signed [COORD_BITS-1:0] origin_y;
    logic signed [COORD_BITS-1:0] origin_z;
    logic signed [COORD_BITS-1:0] velocity_x;
    logic signed [COORD_BITS-1:0] velocity_y;
    logic signed [COORD_BITS-1:0] velocity_z;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic signed [COORD_BITS-1:0] center_z;
    logic        [RADIUS_BITS-1:0] radius;
  } lsi_req_t;

  // Crossing times, signed fixed point
  typedef struct packed {
    logic                        hit;
    logic signed [TIME_BITS-1:0] time_enter;
    logic signed [TIME_BITS-1:0] time_exit;
  } lsi_rsp_t;

  // Status carried alongside the two divider lanes (lane 0 enter, lane 1 exit)
  typedef struct packed {
    logic       hit;
    logic [1:0] neg;
    logic [1:0] sat;
  } lsi_flags_t;

  // Floor of a signed quotient from magnitude quotient, clamped to the time range
  function automatic logic [TIME_BITS-1:0] clamp_time(
    input logic [TIME_BITS-1:0] quo,
    input logic                 inexact,
    input logic                 neg,
    input logic                 sat
  );
    logic [TIME_BITS-1:0] up;
    logic [TIME_BITS-1:0] res;
    up = quo + TIME_BITS'(inexact);
    if (neg && (sat || quo[TIME_BITS-1])) begin
      res = TIME_MIN;
    end else if (neg) begin
      res = -up;
    end else if (sat || quo[TIME_BITS-1]) begin
      res = TIME_MAX;
    end else begin
      res = quo;
    end
    return res;
  endfunction

endpackage

>>> design/lsi_mul.sv
// ============================================================================
// lsi_mul: three-stage unsigned multiplier built from half-width products
// Stage 1 forms four partial products, stage 2 adds the cross terms,
// stage 3 assembles the full product.
// ============================================================================
module lsi_mul #(
  parameter int A_BITS = 8,
  parameter int B_BITS = 8
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [A_BITS-1:0]        a,
  input  logic [B_BITS-1:0]        b,
  output logic [A_BITS+B_BITS-1:0] p
);

  localparam int AL = A_BITS / 2;
  localparam int AH = A_BITS - AL;
  localparam int BL = B_BITS / 2;
  localparam int BH = B_BITS - BL;
  localparam int PW = A_BITS + B_BITS;

  logic [AL+BL-1:0] ll;
  logic [AL+BH-1:0] lh;
  logic [AH+BL-1:0] hl;
  logic [AH+BH-1:0] hh;
  logic [AL+BL-1:0] ll2;
  logic [AH+BH-1:0] hh2;
  logic [PW-1:0]    mid;

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      ll <= a[AL-1:0] * b[BL-1:0];
      lh <= a[AL-1:0] * b[B_BITS-1:BL];
      hl <= a[A_BITS-1:AL] * b[BL-1:0];
      hh <= a[A_BITS-1:AL] * b[B_BITS-1:BL];
    end
  end

  // cross terms
  always_ff @(posedge clk) begin
    if (en) begin
      mid <= (PW'(lh) << BL) + (PW'(hl) << AL);
      ll2 <= ll;
      hh2 <= hh;
    end
  end

  // final sum
  always_ff @(posedge clk) begin
    if (en) begin
      p <= (PW'(hh2) << (AL + BL)) + mid + PW'(ll2);
    end
  end

endmodule

>>> design/lsi_sqrt_cell.sv
// ============================================================================
// lsi_sqrt_cell: one bit of a digit-by-digit integer square root
// Takes two radicand bits, tries the next root bit, hands on to the next cell.
// ============================================================================
module lsi_sqrt_cell #(
  parameter int R_BITS   = 8,
  parameter int PAY_BITS = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  up_vld,
  input  logic [2*R_BITS-1:0]   up_rad,
  input  logic [R_BITS+1:0]     up_rem,
  input  logic [R_BITS-1:0]     up_root,
  input  logic [PAY_BITS-1:0]   up_pay,
  output logic                  dn_vld,
  output logic [2*R_BITS-1:0]   dn_rad,
  output logic [R_BITS+1:0]     dn_rem,
  output logic [R_BITS-1:0]     dn_root,
  output logic [PAY_BITS-1:0]   dn_pay
);

  localparam int CUR_W = R_BITS + 4;

  logic [CUR_W-1:0] cur;
  logic [CUR_W-1:0] trial;
  logic [CUR_W-1:0] diff;
  logic             ge;

  // trial subtract of 4*root + 1
  always_comb begin
    cur   = {up_rem, up_rad[2*R_BITS-1 -: 2]};
    trial = CUR_W'({up_root, 2'b01});
    diff  = cur - trial;
    ge    = (cur >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_vld <= 1'b0;
    end else if (en) begin
      dn_vld <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn_rad  <= up_rad << 2;
      dn_rem  <= ge ? diff[R_BITS+1:0] : cur[R_BITS+1:0];
      dn_root <= {up_root[R_BITS-2:0], ge};
      dn_pay  <= up_pay;
    end
  end

endmodule

>>> design/lsi_div_cell.sv
// ============================================================================
// lsi_div_cell: one quotient bit of a restoring divide, two lanes
// Both lanes share the divisor; lane 0 is the entry time, lane 1 the exit.
// ============================================================================
module lsi_div_cell #(
  parameter int V_BITS = 8
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      en,
  input  logic                                      up_vld,
  input  logic [V_BITS-1:0]                         up_vv,
  input  logic [1:0][V_BITS-1:0]                    up_rem,
  input  logic [1:0][lsi_pkg::TIME_BITS-1:0]        up_low,
  input  logic [1:0][lsi_pkg::TIME_BITS-1:0]        up_quo,
  input  lsi_pkg::lsi_flags_t                       up_flags,
  output logic                                      dn_vld,
  output logic [V_BITS-1:0]                         dn_vv,
  output logic [1:0][V_BITS-1:0]                    dn_rem,
  output logic [1:0][lsi_pkg::TIME_BITS-1:0]        dn_low,
  output logic [1:0][lsi_pkg::TIME_BITS-1:0]        dn_quo,
  output lsi_pkg::lsi_flags_t                       dn_flags
);

  localparam int TB = lsi_pkg::TIME_BITS;

  logic [1:0][V_BITS:0] cur;
  logic [1:0][V_BITS:0] diff;
  logic [1:0]           ge;

  // shift in the next dividend bit and try the divisor
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      cur[l]  = {up_rem[l], up_low[l][TB-1]};
      diff[l] = cur[l] - {1'b0, up_vv};
      ge[l]   = (cur[l] >= {1'b0, up_vv});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_vld <= 1'b0;
    end else if (en) begin
      dn_vld <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        dn_rem[l] <= ge[l] ? diff[l][V_BITS-1:0] : cur[l][V_BITS-1:0];
        dn_low[l] <= up_low[l] << 1;
        dn_quo[l] <= {up_quo[l][TB-2:0], ge[l]};
      end
      dn_vv    <= up_vv;
      dn_flags <= up_flags;
    end
  end

endmodule

>>> design/line_sphere_intersection_times_unit.sv
// ============================================================================
// line_sphere_intersection_times_unit: track/sphere crossing times
// Forms b = V.d, |V|^2 and the discriminant exactly, takes its square root in
// a chain of root cells and the two floored quotients in a chain of divide
// cells, then clamps the times to signed Q24.16.
// ============================================================================
//
//   channel | signals                          | moves
//   --------+----------------------------------+------------------------------
//   request | req_valid, req_ready, req        | track and sphere, one a cycle
//   response| rsp_valid, rsp_ready, rsp        | hit flag and the two times
//
// One request enters per cycle while req_ready is high; each then passes
// the front stages, the root cell chain and the divide cell chain in turn.
// The pipeline moves as a whole; a one-entry skid behind the response
// register lets requests flow while a response waits, and req_ready drops
// only once that skid holds a response too.
// Reset (rst, synchronous) empties every stage; no warm-up is needed.
//
module line_sphere_intersection_times_unit #(
  parameter int TIME_FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  lsi_pkg::lsi_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output lsi_pkg::lsi_rsp_t rsp
);

  localparam int C    = lsi_pkg::COORD_BITS;
  localparam int F    = TIME_FRAC_BITS;
  localparam int TB   = lsi_pkg::TIME_BITS;
  localparam int DW   = C + 1;            // offset O - C
  localparam int PRW  = DW + C;           // v*d
  localparam int BW   = PRW + 2;          // b, signed
  localparam int SQW  = 2 * DW;           // d*d
  localparam int VPW  = 2 * C;            // v*v
  localparam int VW   = VPW + 2;          // |v|^2
  localparam int RRW  = 2 * (C - 1);      // R*R
  localparam int EW   = SQW + 3;          // |d|^2 - R^2, signed
  localparam int PW   = (2 * BW > VW + EW) ? 2 * BW : VW + EW;
  localparam int DSW  = PW + 2;           // discriminant, signed
  localparam int DM   = PW + 1;           // positive discriminant
  localparam int RW   = (DM + 1) / 2 + F; // root bits
  localparam int NW   = ((BW + F > RW) ? BW + F : RW) + 2;
  localparam int CW   = (NW > VW + TB) ? NW : VW + TB;
  localparam int PAYW = 2 + BW + VW;

  logic en;
  logic skid_vld;
  lsi_pkg::lsi_rsp_t skid;
  lsi_pkg::lsi_rsp_t pipe_rsp;

  assign en        = !skid_vld;
  assign req_ready = !skid_vld;

  // ---------------------------------------------------------------- front
  logic [8:0] vld;

  logic signed [DW-1:0]  d1 [3];
  logic signed [C-1:0]   v1 [3];
  logic [C-2:0]          r1;
  logic signed [PRW-1:0] vd2 [3];
  logic [SQW-1:0]        dd2 [3];
  logic [VPW-1:0]        vv2 [3];
  logic [RRW-1:0]        rr2;
  logic signed [BW-1:0]  b3;
  logic [VW-1:0]         vv3;
  logic signed [EW-1:0]  e3;
  logic                  bneg4;
  logic [BW-1:0]         bmag4;
  logic                  eneg4;
  logic [EW-1:0]         emag4;
  logic [VW-1:0]         vv4;
  logic                  side_bneg [3];
  logic [BW-1:0]         side_bmag [3];
  logic                  side_eneg [3];
  logic [VW-1:0]         side_vv [3];
  logic [2*BW-1:0]       bb7;
  logic [VW+EW-1:0]      ve7;
  logic signed [DSW-1:0] disc8;
  logic                  bneg8;
  logic [BW-1:0]         bmag8;
  logic [VW-1:0]         vv8;
  logic                  hit9;
  logic [DM-1:0]         disc9;
  logic                  bneg9;
  logic [BW-1:0]         bmag9;
  logic [VW-1:0]         vv9;

  // stage valids up to the root chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[7:0], req_valid};
    end
  end

  // offsets, products, sums, magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= DW'(req.origin_x) - DW'(req.center_x);
      d1[1] <= DW'(req.origin_y) - DW'(req.center_y);
      d1[2] <= DW'(req.origin_z) - DW'(req.center_z);
      v1[0] <= req.velocity_x;
      v1[1] <= req.velocity_y;
      v1[2] <= req.velocity_z;
      r1    <= req.radius;

      for (int i = 0; i < 3; i++) begin
        vd2[i] <= PRW'(d1[i]) * PRW'(v1[i]);
        dd2[i] <= SQW'(d1[i]) * SQW'(d1[i]);
        vv2[i] <= VPW'(v1[i]) * VPW'(v1[i]);
      end
      rr2 <= RRW'(r1) * RRW'(r1);

      b3  <= BW'(vd2[0]) + BW'(vd2[1]) + BW'(vd2[2]);
      vv3 <= VW'(vv2[0]) + VW'(vv2[1]) + VW'(vv2[2]);
      e3  <= EW'(dd2[0]) + EW'(dd2[1]) + EW'(dd2[2]) - EW'(rr2);

      bneg4 <= b3[BW-1];
      bmag4 <= b3[BW-1] ? -b3 : b3;
      eneg4 <= e3[EW-1];
      emag4 <= e3[EW-1] ? -e3 : e3;
      vv4   <= vv3;
    end
  end

  // b*b and |v|^2 * |e|
  lsi_mul #(.A_BITS(BW), .B_BITS(BW)) u_mul_bb (
    .clk (clk),
    .en  (en),
    .a   (bmag4),
    .b   (bmag4),
    .p   (bb7)
  );

  lsi_mul #(.A_BITS(VW), .B_BITS(EW)) u_mul_ve (
    .clk (clk),
    .en  (en),
    .a   (vv4),
    .b   (emag4),
    .p   (ve7)
  );

  // side data alongside the multipliers, then the discriminant
  always_ff @(posedge clk) begin
    if (en) begin
      side_bneg[0] <= bneg4;
      side_bmag[0] <= bmag4;
      side_eneg[0] <= eneg4;
      side_vv[0]   <= vv4;
      for (int i = 1; i < 3; i++) begin
        side_bneg[i] <= side_bneg[i-1];
        side_bmag[i] <= side_bmag[i-1];
        side_eneg[i] <= side_eneg[i-1];
        side_vv[i]   <= side_vv[i-1];
      end

      disc8 <= side_eneg[2] ? DSW'(bb7) + DSW'(ve7) : DSW'(bb7) - DSW'(ve7);
      bneg8 <= side_bneg[2];
      bmag8 <= side_bmag[2];
      vv8   <= side_vv[2];

      hit9  <= !disc8[DSW-1] && (disc8 != '0) && (vv8 != '0);
      disc9 <= disc8[DM-1:0];
      bneg9 <= bneg8;
      bmag9 <= bmag8;
      vv9   <= vv8;
    end
  end

  // ------------------------------------------------------------ root chain
  logic                sq_vld  [RW+1];
  logic [2*RW-1:0]     sq_rad  [RW+1];
  logic [RW+1:0]       sq_rem  [RW+1];
  logic [RW-1:0]       sq_root [RW+1];
  logic [PAYW-1:0]     sq_pay  [RW+1];

  assign sq_vld[0]  = vld[8];
  assign sq_rad[0]  = (2*RW)'({disc9, {(2*F){1'b0}}});
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_pay[0]  = {hit9, bneg9, bmag9, vv9};

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    lsi_sqrt_cell #(.R_BITS(RW), .PAY_BITS(PAYW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .up_vld  (sq_vld[k]),
      .up_rad  (sq_rad[k]),
      .up_rem  (sq_rem[k]),
      .up_root (sq_root[k]),
      .up_pay  (sq_pay[k]),
      .dn_vld  (sq_vld[k+1]),
      .dn_rad  (sq_rad[k+1]),
      .dn_rem  (sq_rem[k+1]),
      .dn_root (sq_root[k+1]),
      .dn_pay  (sq_pay[k+1])
    );
  end

  // -------------------------------------------------------------- numerators
  logic              hit_s;
  logic              bneg_s;
  logic [BW-1:0]     bmag_s;
  logic [VW-1:0]     vv_s;
  logic [NW-1:0]     bsh;

  assign {hit_s, bneg_s, bmag_s, vv_s} = sq_pay[RW];
  assign bsh = NW'(bmag_s) << F;

  logic [2:0]           nv;
  logic signed [NW-1:0] p1;
  logic signed [NW-1:0] m1;
  logic                 hit1, bneg1;
  logic [VW-1:0]        vv1;
  logic [NW-1:0]        mag2 [2];
  logic [1:0]           neg2;
  logic                 hit2;
  logic [VW-1:0]        vv2n;
  logic [NW-1:0]        mabs;

  assign mabs = m1[NW-1] ? -m1 : m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      nv <= '0;
    end else if (en) begin
      nv <= {nv[1:0], sq_vld[RW]};
    end
  end

  logic [1:0][VW-1:0] dv_rem0;
  logic [1:0][TB-1:0] dv_low0;
  lsi_pkg::lsi_flags_t flags3;
  logic [VW-1:0]       vv3n;

  // P = |b|*2^F + S, M = |b|*2^F - S; the times are -P/-M or M/P by sign of b
  always_ff @(posedge clk) begin
    if (en) begin
      p1    <= bsh + NW'(sq_root[RW]);
      m1    <= bsh - NW'(sq_root[RW]);
      hit1  <= hit_s;
      bneg1 <= bneg_s;
      vv1   <= vv_s;

      if (bneg1) begin
        mag2[0] <= mabs;
        neg2[0] <= m1[NW-1];
        mag2[1] <= p1;
        neg2[1] <= 1'b0;
      end else begin
        mag2[0] <= p1;
        neg2[0] <= (p1 != '0);
        mag2[1] <= mabs;
        neg2[1] <= !m1[NW-1] && (m1 != '0);
      end
      hit2 <= hit1;
      vv2n <= vv1;

      // quotient wider than the time field saturates outright
      for (int l = 0; l < 2; l++) begin
        flags3.sat[l] <= CW'(mag2[l]) >= CW'({vv2n, {TB{1'b0}}});
        dv_rem0[l]    <= VW'(mag2[l] >> TB);
        dv_low0[l]    <= mag2[l][TB-1:0];
      end
      flags3.neg <= neg2;
      flags3.hit <= hit2;
      vv3n       <= vv2n;
    end
  end

  // ---------------------------------------------------------- divide chain
  logic                 dv_vld   [TB+1];
  logic [VW-1:0]        dv_vv    [TB+1];
  logic [1:0][VW-1:0]   dv_rem   [TB+1];
  logic [1:0][TB-1:0]   dv_low   [TB+1];
  logic [1:0][TB-1:0]   dv_quo   [TB+1];
  lsi_pkg::lsi_flags_t  dv_flags [TB+1];

  assign dv_vld[0]   = nv[2];
  assign dv_vv[0]    = vv3n;
  assign dv_rem[0]   = dv_rem0;
  assign dv_low[0]   = dv_low0;
  assign dv_quo[0]   = '0;
  assign dv_flags[0] = flags3;

  for (genvar k = 0; k < TB; k++) begin : g_div
    lsi_div_cell #(.V_BITS(VW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .up_vld   (dv_vld[k]),
      .up_vv    (dv_vv[k]),
      .up_rem   (dv_rem[k]),
      .up_low   (dv_low[k]),
      .up_quo   (dv_quo[k]),
      .up_flags (dv_flags[k]),
      .dn_vld   (dv_vld[k+1]),
      .dn_vv    (dv_vv[k+1]),
      .dn_rem   (dv_rem[k+1]),
      .dn_low   (dv_low[k+1]),
      .dn_quo   (dv_quo[k+1]),
      .dn_flags (dv_flags[k+1])
    );
  end

  // ---------------------------------------------------------- clamp, output
  lsi_pkg::lsi_flags_t fl;
  assign fl = dv_flags[TB];

  always_comb begin
    pipe_rsp.hit        = fl.hit;
    pipe_rsp.time_enter = '0;
    pipe_rsp.time_exit  = '0;
    if (fl.hit) begin
      pipe_rsp.time_enter = lsi_pkg::clamp_time(dv_quo[TB][0], (dv_rem[TB][0] != '0),
                                                fl.neg[0], fl.sat[0]);
      pipe_rsp.time_exit  = lsi_pkg::clamp_time(dv_quo[TB][1], (dv_rem[TB][1] != '0),
                                                fl.neg[1], fl.sat[1]);
    end
  end

  // response register with a one-entry skid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (!rsp_valid || rsp_ready) begin
      if (skid_vld) begin
        rsp_valid <= 1'b1;
        skid_vld  <= 1'b0;
      end else begin
        rsp_valid <= dv_vld[TB];
      end
    end else if (dv_vld[TB] && en) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rsp_valid || rsp_ready) begin
      rsp <= skid_vld ? skid : pipe_rsp;
    end else if (en) begin
      skid <= pipe_rsp;
    end
  end

endmodule

>>> design/lsi_check.sv
// ============================================================================
// lsi_check: port-level checks for the intersection unit
// Response hold, empty times on a miss, time order, reset state.
// ============================================================================
module lsi_check (
  input logic              clk,
  input logic              rst,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input lsi_pkg::lsi_rsp_t rsp
);

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // a miss carries zero times
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.hit |-> rsp.time_enter == '0 && rsp.time_exit == '0)
    else $error("miss with nonzero times");

  // entry never after exit
  a_order: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.hit |-> rsp.time_enter <= rsp.time_exit)
    else $error("entry time after exit time");

  // reset empties the output and opens the input
  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("not empty after reset");

endmodule

bind line_sphere_intersection_times_unit lsi_check u_lsi_check (.*);

>>> tb/sv/tb_line_sphere_intersection_times_unit.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_line_sphere_intersection_times_unit: track/sphere crossing-time checks
// Queue-fed driver and clocked monitor around the unit. Each accepted request
// is run through an exact wide-integer model of the crossing times. Each
// response is compared with the oldest expected one. Random stalls are applied
// on both sides, with one long response hold-off and one full drain pause.
// ============================================================================
module tb_line_sphere_intersection_times_unit;

  localparam int FRAC       = 16;
  localparam int N_RANDOM   = 1830;
  localparam int LATENCY    = 121;
  localparam int HOLD_AT    = 300;
  localparam int HOLD_LEN   = 400;
  localparam int CALM_AFTER = 1550;
  localparam int CB         = lsi_pkg::COORD_BITS;
  localparam int RB         = lsi_pkg::RADIUS_BITS;
  localparam int TB         = lsi_pkg::TIME_BITS;

  typedef struct {
    lsi_pkg::lsi_req_t req;
    bit                drain;
  } pending_t;

  logic              clk;
  logic              rst;
  logic              req_valid;
  logic              req_ready;
  lsi_pkg::lsi_req_t req;
  logic              rsp_valid;
  logic              rsp_ready;
  lsi_pkg::lsi_rsp_t rsp;

  pending_t          pending_q[$];
  lsi_pkg::lsi_rsp_t times_q[$];
  int       n_accepted;
  int       n_errors;
  bit       req_taken;
  int       send_idle;
  int       recv_idle;
  int       hold_cnt;
  bit       hold_done;

  line_sphere_intersection_times_unit #(.TIME_FRAC_BITS(FRAC)) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sign-extend a coordinate to the wide working width
  function automatic logic signed [255:0] widen(input logic [CB-1:0] f);
    return {{(256-CB){f[CB-1]}}, f};
  endfunction

  function automatic logic [255:0] isqrt(input logic [255:0] n);
    logic [255:0] r;
    logic [255:0] c;
    r = '0;
    for (int i = 127; i >= 0; i--) begin
      c = r | (256'd1 << i);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  // Floored quotient clamped to the signed time range
  function automatic logic [TB-1:0] floor_time(
    input logic signed [255:0] num,
    input logic signed [255:0] vv
  );
    logic signed [255:0] q;
    logic signed [255:0] lo;
    logic signed [255:0] hi;
    lo = -(256'sd1 <<< (TB - 1));
    hi = (256'sd1 <<< (TB - 1)) - 1;
    q = num / vv;
    if (num < 0 && (num % vv) != 0) q = q - 1;
    if (q < lo) q = lo;
    if (q > hi) q = hi;
    return q[TB-1:0];
  endfunction

  function automatic lsi_pkg::lsi_rsp_t crossing_times(input lsi_pkg::lsi_req_t r);
    logic signed [255:0] dx, dy, dz, vx, vy, vz, rad;
    logic signed [255:0] b, vv, e, disc, s;
    lsi_pkg::lsi_rsp_t o;
    dx  = widen(r.origin_x) - widen(r.center_x);
    dy  = widen(r.origin_y) - widen(r.center_y);
    dz  = widen(r.origin_z) - widen(r.center_z);
    vx  = widen(r.velocity_x);
    vy  = widen(r.velocity_y);
    vz  = widen(r.velocity_z);
    rad = {{(256-RB){1'b0}}, r.radius};
    b    = vx * dx + vy * dy + vz * dz;
    vv   = vx * vx + vy * vy + vz * vz;
    e    = dx * dx + dy * dy + dz * dz - rad * rad;
    disc = b * b - vv * e;
    o = '0;
    if (disc > 0 && vv != 0) begin
      s = isqrt(disc <<< (2 * FRAC));
      o.hit        = 1'b1;
      o.time_enter = floor_time(-(b <<< FRAC) - s, vv);
      o.time_exit  = floor_time(-(b <<< FRAC) + s, vv);
    end
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [TB-1:0] got,
                                 input logic [TB-1:0] want);
    $display("mismatch %s: got %h want %h (response %0d)", what, got, want,
             n_accepted - times_q.size());
    n_errors++;
  endtask

  task automatic add_req(input lsi_pkg::lsi_req_t r, input bit drain = 1'b0);
    pending_t p;
    p.req   = r;
    p.drain = drain;
    pending_q.push_back(p);
  endtask

  function automatic lsi_pkg::lsi_req_t make_req(
    input int ox, input int oy, input int oz, input int vx, input int vy, input int vz,
    input int cx, input int cy, input int cz, input int rad
  );
    lsi_pkg::lsi_req_t r;
    r.origin_x   = CB'(ox);
    r.origin_y   = CB'(oy);
    r.origin_z   = CB'(oz);
    r.velocity_x = CB'(vx);
    r.velocity_y = CB'(vy);
    r.velocity_z = CB'(vz);
    r.center_x   = CB'(cx);
    r.center_y   = CB'(cy);
    r.center_z   = CB'(cz);
    r.radius     = RB'(rad);
    return r;
  endfunction

  // Random request: full range, small scene with likely hits, huge sphere, or tiny velocity
  function automatic lsi_pkg::lsi_req_t rand_req();
    lsi_pkg::lsi_req_t r;
    logic [255:0]      raw;
    int                kind;
    int                t;
    kind = $urandom_range(0, 9);
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r = raw[$bits(lsi_pkg::lsi_req_t)-1:0];
    if (kind < 4) begin
      t = $urandom_range(0, 20);
      r.origin_x   = CB'($urandom_range(0, 2000) - 1000);
      r.origin_y   = CB'($urandom_range(0, 2000) - 1000);
      r.origin_z   = CB'($urandom_range(0, 2000) - 1000);
      r.velocity_x = CB'($urandom_range(0, 200) - 100);
      r.velocity_y = CB'($urandom_range(0, 200) - 100);
      r.velocity_z = CB'($urandom_range(0, 200) - 100);
      r.center_x   = CB'(r.origin_x + r.velocity_x * t + $urandom_range(0, 40) - 20);
      r.center_y   = CB'(r.origin_y + r.velocity_y * t + $urandom_range(0, 40) - 20);
      r.center_z   = CB'(r.origin_z + r.velocity_z * t + $urandom_range(0, 40) - 20);
      r.radius     = RB'($urandom_range(0, 2000));
    end else if (kind < 7) begin
      r.radius = RB'($urandom_range(4194304, 8388607));
      r.origin_x = CB'(r.center_x + $urandom_range(0, 4000000) - 2000000);
    end else if (kind == 7) begin
      r.velocity_x = CB'($urandom_range(0, 4) - 2);
      r.velocity_y = CB'($urandom_range(0, 4) - 2);
      r.velocity_z = CB'($urandom_range(0, 4) - 2);
    end
    return r;
  endfunction

  // Stimulus, then wait for the pipeline to empty and give the verdict
  initial begin
    lsi_pkg::lsi_req_t r;
    rst = 1'b1;
    n_errors = 0;
    n_accepted = 0;
    hold_done = 1'b0;
    add_req(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 8388607));
    add_req(make_req(0, -5, 0, 1, 0, 0, 0, 0, 0, 5));
    add_req(make_req(-10, 0, 0, 1, 0, 0, 0, 0, 0, 3));
    add_req(make_req(-10, 0, 0, -1, 0, 0, 0, 0, 0, 3));
    add_req(make_req(0, 0, 0, 3, 4, 0, 0, 0, 0, 7));
    add_req(make_req(0, 0, 0, 1, 1, 1, 100, 0, 0, 5));
    add_req(make_req(1, 2, 3, 7, -3, 2, 1, 2, 3, 0));
    add_req(make_req(1, 2, 3, 7, -3, 2, 1, 2, 3, 1));
    add_req(make_req(8388607, 0, 0, 1, 0, 0, -8388608, 0, 0, 8388607));
    add_req(make_req(-8388608, 0, 0, -1, 0, 0, 8388607, 0, 0, 8388607));
    add_req(make_req(0, 0, 0, 1, 0, 0, 0, 0, 0, 8388607));
    add_req(make_req(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                     8388607, 8388607, 8388607, 8388607));
    add_req(make_req(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                     -8388608, -8388608, -8388608, 8388607));
    add_req(make_req(-8388608, 8388607, -8388608, -8388608, 8388607, -8388608,
                     8388607, -8388608, 8388607, 0));
    add_req(make_req(0, 0, 0, -8388608, -8388608, -8388608, 0, 0, 0, 8388607));
    add_req(make_req(100, 100, 100, -1, -1, -1, 0, 0, 0, 50));
    add_req(make_req(0, 0, 0, 0, 0, 1, 0, 0, 0, 1));
    for (int i = 0; i < N_RANDOM; i++) begin
      r = rand_req();
      add_req(r, i == 900);
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait (pending_q.size() == 0 && !req_valid);
    wait (times_q.size() == 0);
    repeat (LATENCY + 50) @(posedge clk);
    if (n_errors == 0 && times_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Request driver: holds a request until accepted, idles in random bursts
  always @(negedge clk) begin
    pending_t p;
    if (rst) begin
      req_valid <= 1'b0;
      req       <= '0;
      send_idle = 0;
      req_taken = 1'b0;
    end else if (!req_valid || req_taken) begin
      req_taken = 1'b0;
      if (send_idle > 0) begin
        send_idle--;
        req_valid <= 1'b0;
      end else if (pending_q.size() != 0 &&
                   !(pending_q[0].drain && times_q.size() != 0)) begin
        p = pending_q.pop_front();
        req       <= p.req;
        req_valid <= 1'b1;
        if (n_accepted < CALM_AFTER && $urandom_range(0, 9) == 0)
          send_idle = $urandom_range(1, 5);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response ready: random stalls plus one long hold-off to back up the pipe
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      recv_idle = 0;
      hold_cnt  = 0;
    end else begin
      if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_cnt  = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_ready <= 1'b0;
      end else if (recv_idle > 0) begin
        recv_idle--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
        if (n_accepted < CALM_AFTER && $urandom_range(0, 9) == 0)
          recv_idle = $urandom_range(1, 5);
      end
    end
  end

  // Request capture and response check at the rising edge
  always @(posedge clk) begin
    lsi_pkg::lsi_rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready) begin
        times_q.push_back(crossing_times(req));
        n_accepted++;
        req_taken = 1'b1;
      end
      if (rsp_valid && rsp_ready) begin
        if (times_q.size() == 0) begin
          report_mismatch("unexpected response", rsp.time_enter, '0);
        end else begin
          want = times_q.pop_front();
          if (rsp.hit !== want.hit) report_mismatch("hit", TB'(rsp.hit), TB'(want.hit));
          if (rsp.time_enter !== want.time_enter)
            report_mismatch("time_enter", rsp.time_enter, want.time_enter);
          if (rsp.time_exit !== want.time_exit)
            report_mismatch("time_exit", rsp.time_exit, want.time_exit);
        end
      end
    end
  end

endmodule
